### src/v86sie_pkg.sv
// Shared types and constants for the virtual-8086 sensitive instruction emulator.
package v86sie_pkg;

	localparam logic [7:0] OP_INT   = 8'hCD;
	localparam logic [7:0] OP_IRET  = 8'hCF;
	localparam logic [7:0] OP_CLI   = 8'hFA;
	localparam logic [7:0] OP_PUSHF = 8'h9C;
	localparam logic [7:0] OP_POPF  = 8'h9D;
	localparam logic [7:0] OP_OUTB  = 8'hEE;
	localparam logic [7:0] OP_OUTW  = 8'hEF;
	localparam logic [7:0] OP_INB   = 8'hEC;
	localparam logic [7:0] OP_INW   = 8'hED;
	localparam logic [7:0] VEC_EXIT = 8'h81;

	localparam logic [15:0] IP_STUCK        = 16'hFFFF;
	localparam int          IF_POS          = 9;
	localparam int          VM_POS          = 17;
	localparam logic [15:0] FLAGS_PUSH_MASK = 16'h0DFF;
	localparam logic [31:0] FLAGS_HIGH_MASK = 32'hFFFF0000;

	typedef enum logic [3:0] {
		KIND_UNKNOWN = 4'd0,
		KIND_INT     = 4'd1,
		KIND_CLI     = 4'd2,
		KIND_PUSHF   = 4'd3,
		KIND_POPF    = 4'd4,
		KIND_OUT     = 4'd5,
		KIND_IN      = 4'd6,
		KIND_IRET    = 4'd7,
		KIND_EXIT    = 4'd8
	} kind_t;

	typedef enum logic [2:0] {
		PORT_NONE    = 3'd0,
		PORT_WR_BYTE = 3'd1,
		PORT_WR_WORD = 3'd2,
		PORT_RD_BYTE = 3'd3,
		PORT_RD_WORD = 3'd4
	} port_op_t;

	typedef enum logic [1:0] {
		WORDS_NONE  = 2'd0,
		WORDS_PUSHF = 2'd1,
		WORDS_INT   = 2'd3
	} write_words_t;

	typedef struct packed {
		logic [7:0]  opcode;
		logic [7:0]  vector;
		logic [15:0] ip_in;
		logic [15:0] code_seg_in;
		logic [31:0] flags_in;
		logic [15:0] stack_ptr_in;
		logic [15:0] stack_seg_in;
		logic [31:0] acc_in;
		logic [15:0] port_reg;
		logic [47:0] stack_words;
		logic [31:0] vector_entry;
		logic [15:0] port_read_data;
	} item_t;

	typedef struct packed {
		kind_t        kind;
		logic [15:0]  ip_out;
		logic [15:0]  code_seg_out;
		logic [31:0]  flags_out;
		logic [15:0]  stack_ptr_out;
		logic [15:0]  stack_seg_out;
		logic [31:0]  acc_out;
		logic [20:0]  mem_write_addr;
		logic [47:0]  mem_write_data;
		write_words_t mem_write_words;
		logic [15:0]  port_addr;
		port_op_t     port_op;
	} result_t;

endpackage

### src/v86sie_exec.sv
// Decode and register update for one trapped instruction.
module v86sie_exec
	import v86sie_pkg::*;
(
	input  item_t   item,
	input  logic    vif,
	output result_t result,
	output logic    vif_next
);

	logic [15:0] w0, w1, w2;
	logic [15:0] ip_inc;
	logic [20:0] seg_base;
	logic [20:0] flat_down;
	logic [20:0] flat_up;
	logic [15:0] sp_dec;
	logic [15:0] push_word;

	assign w0 = item.stack_words[15:0];
	assign w1 = item.stack_words[31:16];
	assign w2 = item.stack_words[47:32];
	assign ip_inc = item.ip_in + 16'd1;
	assign seg_base = {1'b0, item.stack_seg_in, 4'b0000};
	assign flat_down = seg_base + {5'b0, item.stack_ptr_in} - 21'd6;
	assign flat_up = seg_base + {5'b0, item.stack_ptr_in} + 21'd6;
	assign sp_dec = item.stack_ptr_in - 16'd2;

	always_comb begin
		push_word = item.flags_in[15:0] & FLAGS_PUSH_MASK;
		push_word[IF_POS] = vif;
	end

	always_comb begin
		result.kind            = KIND_UNKNOWN;
		result.ip_out          = item.ip_in;
		result.code_seg_out    = item.code_seg_in;
		result.flags_out       = item.flags_in;
		result.stack_ptr_out   = item.stack_ptr_in;
		result.stack_seg_out   = item.stack_seg_in;
		result.acc_out         = item.acc_in;
		result.mem_write_addr  = '0;
		result.mem_write_data  = '0;
		result.mem_write_words = WORDS_NONE;
		result.port_addr       = '0;
		result.port_op         = PORT_NONE;
		vif_next               = vif;

		if (item.ip_in != IP_STUCK) begin
			unique case (item.opcode) inside
				OP_INT: begin
					if (item.vector == VEC_EXIT) begin
						result.kind = KIND_EXIT;
					end else begin
						result.kind                   = KIND_INT;
						result.mem_write_addr         = flat_down;
						result.mem_write_data[15:0]   = item.ip_in;
						result.mem_write_data[31:16]  = item.code_seg_in;
						result.mem_write_data[47:32]  = item.flags_in[15:0];
						result.mem_write_data[32 + IF_POS] = 1'b1;
						result.mem_write_words        = WORDS_INT;
						result.stack_ptr_out          = flat_down[15:0];
						result.stack_seg_out          = {flat_down[19:16], 12'h000};
						result.ip_out                 = item.vector_entry[15:0];
						result.code_seg_out           = item.vector_entry[31:16];
					end
				end
				OP_IRET: begin
					result.kind          = KIND_IRET;
					result.ip_out        = w0 + 16'd2;
					result.code_seg_out  = w1;
					result.flags_out     = (item.flags_in & FLAGS_HIGH_MASK) | {16'h0000, w2};
					result.stack_ptr_out = flat_up[15:0];
					result.stack_seg_out = {flat_up[19:16], 12'h000};
				end
				OP_CLI: begin
					result.kind   = KIND_CLI;
					result.ip_out = ip_inc;
					vif_next      = 1'b0;
				end
				OP_PUSHF: begin
					result.kind                 = KIND_PUSHF;
					result.stack_ptr_out        = sp_dec;
					result.mem_write_addr       = seg_base + {5'b0, sp_dec};
					result.mem_write_data[15:0] = push_word;
					result.mem_write_words      = WORDS_PUSHF;
					result.ip_out               = ip_inc;
				end
				OP_POPF: begin
					result.kind                 = KIND_POPF;
					result.flags_out            = {16'h0000, w0};
					result.flags_out[IF_POS]    = 1'b1;
					result.flags_out[VM_POS]    = 1'b1;
					vif_next                    = w0[IF_POS];
					result.stack_ptr_out        = item.stack_ptr_in + 16'd2;
					result.ip_out               = ip_inc;
				end
				OP_OUTB, OP_OUTW: begin
					result.kind      = KIND_OUT;
					result.port_addr = item.port_reg;
					result.port_op   = (item.opcode == OP_OUTB) ? PORT_WR_BYTE : PORT_WR_WORD;
					result.ip_out    = ip_inc;
				end
				OP_INB: begin
					result.kind          = KIND_IN;
					result.acc_out[7:0]  = item.port_read_data[7:0];
					result.port_addr     = item.port_reg;
					result.port_op       = PORT_RD_BYTE;
					result.ip_out        = ip_inc;
				end
				OP_INW: begin
					result.kind          = KIND_IN;
					result.acc_out[15:0] = item.port_read_data;
					result.port_addr     = item.port_reg;
					result.port_op       = PORT_RD_WORD;
					result.ip_out        = ip_inc;
				end
				default: begin
					result.kind = KIND_UNKNOWN;
				end
			endcase
		end
	end

endmodule

### src/v86_sensitive_instruction_emulator_top.sv
// Top level of the virtual-8086 sensitive instruction emulator.
//
// The caller offers one trapped instruction per transaction on the item
// channel: the opcode bytes, the guest registers, three prefetched stack
// words, the vector-table entry and the port read data. The block returns
// one transaction on the result channel for each item: a kind code, the
// updated registers, at most one stack write and at most one port operation.
// A transaction moves at a rising edge where valid is high and stall is low.
// The item is registered when accepted, then decoded and placed in the
// result register. Throughput is one item per cycle while the receiver
// does not stall; the only serial element is the one-bit virtual interrupt
// flag, which is updated as each item enters the result register, so the
// next item in order always sees it.
// When the receiver stalls, the result register holds and the input
// register may still fill; the item channel stalls only once both are full.
// Reset empties both registers and clears the virtual interrupt flag.
module v86_sensitive_instruction_emulator_top
	import v86sie_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic    valid_s1;
	item_t   item_s1;
	logic    vif_q;
	logic    res_valid_q;
	result_t res_q;
	result_t exec_res;
	logic    vif_next;
	logic    adv_out;
	logic    take_s1;
	logic    accept;

	assign adv_out    = !res_valid_q || !result_stall;
	assign take_s1    = valid_s1 && adv_out;
	assign item_stall = valid_s1 && !adv_out;
	assign accept     = item_valid && !item_stall;

	v86sie_exec u_exec (
		.item     (item_s1),
		.vif      (vif_q),
		.result   (exec_res),
		.vif_next (vif_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			vif_q       <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_out) begin
				res_valid_q <= valid_s1;
			end
			if (take_s1) begin
				vif_q <= vif_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (take_s1) begin
			res_q <= exec_res;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

### src/v86sie_checker.sv
// Port-level checks for the emulator top level, attached by bind.
module v86sie_checker
	import v86sie_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// A result that is held back must not change under the receiver.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// The item channel only stalls while results are being held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("item channel stalled without a held result");

	// Instructions that change nothing make no stack write and no port access.
	a_noop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind == KIND_UNKNOWN || result.kind == KIND_EXIT)
		|-> result.mem_write_words == WORDS_NONE && result.port_op == PORT_NONE)
		else $error("unknown or exit instruction had side effects");

	// A port address is shown only with a port operation.
	a_port_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.port_op == PORT_NONE |-> result.port_addr == 16'h0000)
		else $error("port address without port operation");

	// An accepted item with nothing queued shows its result after the input and result registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && !result_valid |=> ##1 result_valid)
		else $error("result missing after accepted item");

endmodule

bind v86_sensitive_instruction_emulator_top v86sie_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
